[rtl/cqhs_pkg.sv]
package cqhs_pkg;

   // controller states
   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_LOOK,
      ST_DECIDE,
      ST_WALK,
      ST_FIN,
      ST_EMIT
   } state_type;

   // input commands
   localparam logic CMD_ADD    = 1'b0;
   localparam logic CMD_REPORT = 1'b1;

   // configuration register indexes
   localparam logic CSR_HAS_QUALITY = 1'b0;
   localparam logic CSR_MIN_QUALITY = 1'b1;

   localparam logic              HAS_QUALITY_RESET = 1'b1;
   localparam logic signed [7:0] MIN_QUALITY_RESET = -8'sd15;

   // statistic codes
   localparam logic [3:0] STAT_COUNT  = 4'd0;
   localparam logic [3:0] STAT_MIN    = 4'd1;
   localparam logic [3:0] STAT_MAX    = 4'd2;
   localparam logic [3:0] STAT_SUM    = 4'd3;
   localparam logic [3:0] STAT_Q1     = 4'd4;
   localparam logic [3:0] STAT_MEDIAN = 4'd5;
   localparam logic [3:0] STAT_Q3     = 4'd6;
   localparam logic [3:0] STAT_IQR    = 4'd7;
   localparam logic [3:0] STAT_LWHISK = 4'd8;
   localparam logic [3:0] STAT_RWHISK = 4'd9;
   localparam logic [3:0] STAT_CNT_A  = 4'd10;
   localparam logic [3:0] STAT_CNT_C  = 4'd11;
   localparam logic [3:0] STAT_CNT_G  = 4'd12;
   localparam logic [3:0] STAT_CNT_T  = 4'd13;
   localparam logic [3:0] STAT_CNT_N  = 4'd14;
   localparam logic [3:0] STAT_STATUS = 4'd15;

   // add status values
   localparam logic [1:0] STS_OK       = 2'd0;
   localparam logic [1:0] STS_BAD_BASE = 2'd1;
   localparam logic [1:0] STS_BAD_QUAL = 2'd2;
   localparam logic [1:0] STS_BAD_COL  = 2'd3;

   localparam logic [7:0] ASCII_A = 8'h41;
   localparam logic [7:0] ASCII_C = 8'h43;
   localparam logic [7:0] ASCII_G = 8'h47;
   localparam logic [7:0] ASCII_T = 8'h54;
   localparam logic [7:0] ASCII_N = 8'h4E;

   localparam int NUM_BASES = 5;

   localparam logic [7:0] MIN_INIT = 8'd100;
   localparam logic [7:0] MAX_INIT = 8'h9C;   // -100

   localparam int SUM_BITS   = 49;
   localparam int VALUE_BITS = 49;
   localparam int STAT_BITS  = 13;

   typedef struct packed {
      logic       valid;
      logic [2:0] slot;
   } base_slot_type;

   typedef struct packed {
      logic clr_step;
      logic cap;
      logic apply;
      logic setup;
      logic walk_step;
      logic fin;
      logic emit_load;
   } cmd_type;

   typedef struct packed {
      logic clr_done;
      logic is_report;
      logic col_bad;
      logic walk_done;
      logic emit_last;
      logic out_free;
   } sts_type;

   function automatic base_slot_type base_slot(input logic [7:0] b);
      base_slot_type r;
      r.valid = 1'b1;
      unique case (b)
         ASCII_A: r.slot = 3'd0;
         ASCII_C: r.slot = 3'd1;
         ASCII_G: r.slot = 3'd2;
         ASCII_T: r.slot = 3'd3;
         ASCII_N: r.slot = 3'd4;
         default: begin
            r.valid = 1'b0;
            r.slot  = 3'd0;
         end
      endcase
      return r;
   endfunction

endpackage

[rtl/cqhs_ifs.sv]
interface cqhs_req_if;
   logic              valid;
   logic              ready;
   logic              command;
   logic [7:0]        column;
   logic [7:0]        base;
   logic signed [7:0] quality;
   logic [23:0]       weight;

   modport source (output valid, command, column, base, quality, weight, input ready);
   modport sink (input valid, command, column, base, quality, weight, output ready);
endinterface

interface cqhs_rsp_if;
   logic               valid;
   logic               ready;
   logic [3:0]         stat_code;
   logic signed [48:0] value;
   logic               last;

   modport source (output valid, stat_code, value, last, input ready);
   modport sink (input valid, stat_code, value, last, output ready);
endinterface

[rtl/cqhs_ctrl.sv]
module cqhs_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   input  cqhs_pkg::sts_type   sts,
   output cqhs_pkg::cmd_type   cmd
);

   cqhs_pkg::state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= cqhs_pkg::ST_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         cqhs_pkg::ST_CLEAR:  if (sts.clr_done) state_in = cqhs_pkg::ST_IDLE;
         cqhs_pkg::ST_IDLE:   if (req_valid) state_in = cqhs_pkg::ST_LOOK;
         cqhs_pkg::ST_LOOK:   state_in = cqhs_pkg::ST_DECIDE;
         cqhs_pkg::ST_DECIDE: begin
            if (sts.is_report && !sts.col_bad) state_in = cqhs_pkg::ST_WALK;
            else if (sts.out_free) state_in = cqhs_pkg::ST_IDLE;
         end
         cqhs_pkg::ST_WALK:   if (sts.walk_done) state_in = cqhs_pkg::ST_FIN;
         cqhs_pkg::ST_FIN:    state_in = cqhs_pkg::ST_EMIT;
         cqhs_pkg::ST_EMIT:   if (sts.out_free && sts.emit_last) state_in = cqhs_pkg::ST_IDLE;
         default:             state_in = cqhs_pkg::ST_CLEAR;
      endcase
   end

   always_comb begin
      cmd       = '0;
      req_ready = 1'b0;
      unique case (state_ff)
         cqhs_pkg::ST_CLEAR:  cmd.clr_step = 1'b1;
         cqhs_pkg::ST_IDLE: begin
            req_ready = 1'b1;
            cmd.cap   = req_valid;
         end
         cqhs_pkg::ST_LOOK:   ;
         cqhs_pkg::ST_DECIDE: begin
            if (sts.is_report && !sts.col_bad) cmd.setup = 1'b1;
            else cmd.apply = sts.out_free;
         end
         cqhs_pkg::ST_WALK:   cmd.walk_step = 1'b1;
         cqhs_pkg::ST_FIN:    cmd.fin = 1'b1;
         cqhs_pkg::ST_EMIT:   cmd.emit_load = sts.out_free;
         default:             ;
      endcase
   end

endmodule

[rtl/cqhs_datapath.sv]
module cqhs_datapath #(
   parameter int MAX_COLUMNS = 256,
   parameter int QUAL_LEVELS = 128,
   parameter int COUNT_BITS  = 32
) (
   input  logic                clock,
   input  logic                reset,
   input  cqhs_pkg::cmd_type   cmd,
   output cqhs_pkg::sts_type   sts,
   input  logic                has_quality,
   input  logic signed [7:0]   min_quality,
   input  logic                req_command,
   input  logic [7:0]          req_column,
   input  logic [7:0]          req_base,
   input  logic signed [7:0]   req_quality,
   input  logic [23:0]         req_weight,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output logic [3:0]          rsp_stat_code,
   output logic signed [48:0]  rsp_value,
   output logic                rsp_last
);

   localparam int CB         = COUNT_BITS;
   localparam int COL_BITS   = (MAX_COLUMNS > 1) ? $clog2(MAX_COLUMNS) : 1;
   localparam int BIN_BITS   = $clog2(QUAL_LEVELS);
   localparam int HIST_DEPTH = MAX_COLUMNS * (2 ** BIN_BITS);
   localparam int HA_BITS    = (HIST_DEPTH > 1) ? $clog2(HIST_DEPTH) : 1;
   localparam int CUM_BITS   = CB + BIN_BITS + 1;
   localparam int AW         = ((CB > 24) ? CB : 24) + 1;
   localparam int SB         = cqhs_pkg::SUM_BITS;
   localparam int VB         = cqhs_pkg::VALUE_BITS;
   localparam int TB         = cqhs_pkg::STAT_BITS;
   localparam int NB         = cqhs_pkg::NUM_BASES;

   // column word layout, lsb first
   localparam int OFS_MIN  = 0;
   localparam int OFS_MAX  = 8;
   localparam int OFS_SUM  = 16;
   localparam int OFS_CNT  = OFS_SUM + SB;
   localparam int OFS_SMP  = OFS_CNT + CB;
   localparam int OFS_BASE = OFS_SMP + CB;
   localparam int WORD_W   = OFS_BASE + NB * CB;

   localparam logic [WORD_W-1:0] COL_INIT =
      {{(WORD_W - 16){1'b0}}, cqhs_pkg::MAX_INIT, cqhs_pkg::MIN_INIT};

   function automatic logic [CB-1:0] sat_add(input logic [CB-1:0] a, input logic [23:0] b);
      logic [AW-1:0] s;
      s = AW'(a) + AW'(b);
      if (|s[AW-1:CB]) return {CB{1'b1}};
      return s[CB-1:0];
   endfunction

   // captured item
   logic              cmd_ff;
   logic [7:0]        col_ff;
   logic [7:0]        base_ff;
   logic signed [7:0] qual_ff;
   logic [23:0]       weight_ff;

   always_ff @(posedge clock) begin
      if (cmd.cap) begin
         cmd_ff    <= req_command;
         col_ff    <= req_column;
         base_ff   <= req_base;
         qual_ff   <= req_quality;
         weight_ff <= req_weight;
      end
   end

   logic [COL_BITS-1:0]       col_idx;
   logic signed [8:0]         bin_val;
   logic [BIN_BITS-1:0]       bin_idx;
   logic                      col_bad;
   logic                      qual_bad;
   cqhs_pkg::base_slot_type   slot;
   logic [1:0]                add_sts;

   assign col_idx  = COL_BITS'(col_ff);
   assign bin_val  = 9'(qual_ff) - 9'(min_quality);
   assign bin_idx  = bin_val[BIN_BITS-1:0];
   assign col_bad  = int'(col_ff) >= MAX_COLUMNS;
   assign qual_bad = has_quality && ((bin_val < 0) || (int'(bin_val) >= QUAL_LEVELS));
   assign slot     = cqhs_pkg::base_slot(base_ff);

   always_comb begin
      priority if (col_bad) add_sts = cqhs_pkg::STS_BAD_COL;
      else if (!slot.valid) add_sts = cqhs_pkg::STS_BAD_BASE;
      else if (qual_bad)    add_sts = cqhs_pkg::STS_BAD_QUAL;
      else                  add_sts = cqhs_pkg::STS_OK;
   end

   // clearing sweep
   logic [HA_BITS-1:0] clr_cnt_ff;
   logic               clr_done;
   assign clr_done = clr_cnt_ff == HA_BITS'(HIST_DEPTH - 1);

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_cnt_ff <= '0;
      end else if (cmd.clr_step && !clr_done) begin
         clr_cnt_ff <= clr_cnt_ff + 1'b1;
      end
   end

   // walk registers
   logic [BIN_BITS:0]   wcnt_ff;
   logic [BIN_BITS-1:0] wbin;
   assign wbin = wcnt_ff[BIN_BITS-1:0];

   // memories
   logic [WORD_W-1:0] col_mem [MAX_COLUMNS];
   logic [CB-1:0]     hist_mem [HIST_DEPTH];
   logic [WORD_W-1:0] col_rd_ff;
   logic [CB-1:0]     hist_rd_ff;
   logic [HA_BITS-1:0] hist_raddr;
   logic [HA_BITS-1:0] hist_waddr;
   logic [HA_BITS-1:0] hist_addr_add;
   logic [COL_BITS-1:0] col_waddr;
   logic               do_add;
   logic [WORD_W-1:0]  col_new;
   logic [CB-1:0]      hist_new;

   assign hist_addr_add = HA_BITS'({col_idx, bin_idx});
   assign hist_raddr    = (cmd.walk_step) ? HA_BITS'({col_idx, wbin}) : hist_addr_add;
   assign hist_waddr    = cmd.clr_step ? clr_cnt_ff : hist_addr_add;
   assign col_waddr     = cmd.clr_step ? COL_BITS'(clr_cnt_ff >> BIN_BITS) : col_idx;
   assign do_add        = cmd.apply && (cmd_ff == cqhs_pkg::CMD_ADD)
                          && (add_sts == cqhs_pkg::STS_OK);

   always_ff @(posedge clock) begin
      col_rd_ff  <= col_mem[col_idx];
      hist_rd_ff <= hist_mem[hist_raddr];
      if (cmd.clr_step) begin
         col_mem[col_waddr]   <= COL_INIT;
         hist_mem[hist_waddr] <= '0;
      end else if (do_add) begin
         col_mem[col_waddr] <= col_new;
         if (has_quality) hist_mem[hist_waddr] <= hist_new;
      end
   end

   // fields of the column word
   logic signed [7:0]    min_old, max_old;
   logic signed [SB-1:0] sum_old;
   logic [CB-1:0]        cnt_old, smp_old;

   assign min_old = col_rd_ff[OFS_MIN +: 8];
   assign max_old = col_rd_ff[OFS_MAX +: 8];
   assign sum_old = col_rd_ff[OFS_SUM +: SB];
   assign cnt_old = col_rd_ff[OFS_CNT +: CB];
   assign smp_old = col_rd_ff[OFS_SMP +: CB];

   // add update
   logic signed [SB:0] sum_wide;
   assign sum_wide = (SB + 1)'(sum_old) + (SB + 1)'(qual_ff);
   assign hist_new = sat_add(hist_rd_ff, 24'd1);

   always_comb begin
      col_new = col_rd_ff;
      if (has_quality) begin
         if (min_old > qual_ff) col_new[OFS_MIN +: 8] = qual_ff;
         if (max_old < qual_ff) col_new[OFS_MAX +: 8] = qual_ff;
         if (sum_wide[SB] != sum_wide[SB-1]) begin
            col_new[OFS_SUM +: SB] = {sum_wide[SB], {(SB - 1){~sum_wide[SB]}}};
         end else begin
            col_new[OFS_SUM +: SB] = sum_wide[SB-1:0];
         end
         col_new[OFS_SMP +: CB] = sat_add(smp_old, 24'd1);
      end
      col_new[OFS_CNT +: CB] = sat_add(cnt_old, weight_ff);
      for (int k = 0; k < NB; k++) begin
         if (slot.slot == 3'(k)) begin
            col_new[OFS_BASE + k * CB +: CB] =
               sat_add(col_rd_ff[OFS_BASE + k * CB +: CB], weight_ff);
         end
      end
   end

   // histogram walk for the three quartiles
   logic [CUM_BITS-1:0] cum_ff;
   logic [CB-1:0]       rank_ff  [3];
   logic [2:0]          found_ff;
   logic [BIN_BITS-1:0] qbin_ff  [3];
   logic [BIN_BITS-1:0] top_ff;
   logic [CUM_BITS-1:0] cum_next;
   logic [BIN_BITS-1:0] cur_bin;
   logic [CB+1:0]       smp3;

   assign cum_next = cum_ff + CUM_BITS'(hist_rd_ff);
   assign cur_bin  = BIN_BITS'(wcnt_ff - 1'b1);
   assign smp3     = (CB + 2)'(smp_old) + ((CB + 2)'(smp_old) << 1);

   always_ff @(posedge clock) begin
      if (cmd.setup) begin
         wcnt_ff    <= '0;
         cum_ff     <= '0;
         found_ff   <= '0;
         top_ff     <= '0;
         rank_ff[0] <= smp_old >> 2;
         rank_ff[1] <= smp_old >> 1;
         rank_ff[2] <= CB'(smp3 >> 2);
      end else if (cmd.walk_step) begin
         wcnt_ff <= wcnt_ff + 1'b1;
         if ((wcnt_ff != '0) && (hist_rd_ff != '0)) begin
            top_ff <= cur_bin;
            cum_ff <= cum_next;
            for (int j = 0; j < 3; j++) begin
               if (!found_ff[j] && (cum_next > CUM_BITS'(rank_ff[j]))) begin
                  found_ff[j] <= 1'b1;
                  qbin_ff[j]  <= cur_bin;
               end
            end
         end
      end
   end

   // box-plot values
   logic signed [10:0]   qv [3];
   logic signed [10:0]   iqr;
   logic signed [TB-1:0] half;
   logic signed [TB-1:0] lw, rw;
   logic signed [TB-1:0] q1_ff, med_ff, q3_ff, iqr_ff, lw_ff, rw_ff;

   always_comb begin
      for (int j = 0; j < 3; j++) begin
         qv[j] = 11'(found_ff[j] ? qbin_ff[j] : top_ff) + 11'(min_quality);
      end
      iqr  = qv[2] - qv[0];
      half = (TB'(iqr) + (TB'(iqr) <<< 1)) >>> 1;
      lw   = TB'(qv[0]) - half;
      if (lw < TB'(min_old)) lw = TB'(min_old);
      rw   = TB'(qv[2]) + half;
      if (rw > TB'(max_old)) rw = TB'(max_old);
   end

   always_ff @(posedge clock) begin
      if (cmd.fin) begin
         if (smp_old == '0) begin
            q1_ff  <= '0;
            med_ff <= '0;
            q3_ff  <= '0;
            iqr_ff <= '0;
            lw_ff  <= '0;
            rw_ff  <= '0;
         end else begin
            q1_ff  <= TB'(qv[0]);
            med_ff <= TB'(qv[1]);
            q3_ff  <= TB'(qv[2]);
            iqr_ff <= TB'(iqr);
            lw_ff  <= lw;
            rw_ff  <= rw;
         end
      end
   end

   // result emission
   logic [3:0]           k_ff;
   logic signed [VB-1:0] emit_val;

   always_ff @(posedge clock) begin
      if (cmd.fin) k_ff <= cqhs_pkg::STAT_COUNT;
      else if (cmd.emit_load) k_ff <= k_ff + 1'b1;
   end

   always_comb begin
      unique case (k_ff)
         cqhs_pkg::STAT_COUNT:  emit_val = VB'(cnt_old);
         cqhs_pkg::STAT_MIN:    emit_val = VB'(min_old);
         cqhs_pkg::STAT_MAX:    emit_val = VB'(max_old);
         cqhs_pkg::STAT_SUM:    emit_val = VB'(sum_old);
         cqhs_pkg::STAT_Q1:     emit_val = VB'(q1_ff);
         cqhs_pkg::STAT_MEDIAN: emit_val = VB'(med_ff);
         cqhs_pkg::STAT_Q3:     emit_val = VB'(q3_ff);
         cqhs_pkg::STAT_IQR:    emit_val = VB'(iqr_ff);
         cqhs_pkg::STAT_LWHISK: emit_val = VB'(lw_ff);
         cqhs_pkg::STAT_RWHISK: emit_val = VB'(rw_ff);
         cqhs_pkg::STAT_CNT_A:  emit_val = VB'(col_rd_ff[OFS_BASE +: CB]);
         cqhs_pkg::STAT_CNT_C:  emit_val = VB'(col_rd_ff[OFS_BASE + CB +: CB]);
         cqhs_pkg::STAT_CNT_G:  emit_val = VB'(col_rd_ff[OFS_BASE + 2 * CB +: CB]);
         cqhs_pkg::STAT_CNT_T:  emit_val = VB'(col_rd_ff[OFS_BASE + 3 * CB +: CB]);
         cqhs_pkg::STAT_CNT_N:  emit_val = VB'(col_rd_ff[OFS_BASE + 4 * CB +: CB]);
         default:               emit_val = '0;
      endcase
   end

   // output register
   logic                 out_valid_ff;
   logic [3:0]           out_code_ff;
   logic signed [VB-1:0] out_value_ff;
   logic                 out_last_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (cmd.apply || cmd.emit_load) begin
         out_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.apply) begin
         out_code_ff  <= cqhs_pkg::STAT_STATUS;
         out_value_ff <= VB'(add_sts);
         out_last_ff  <= 1'b1;
      end else if (cmd.emit_load) begin
         out_code_ff  <= k_ff;
         out_value_ff <= emit_val;
         out_last_ff  <= k_ff == cqhs_pkg::STAT_CNT_N;
      end
   end

   assign rsp_valid     = out_valid_ff;
   assign rsp_stat_code = out_code_ff;
   assign rsp_value     = out_value_ff;
   assign rsp_last      = out_last_ff;

   assign sts.clr_done  = clr_done;
   assign sts.is_report = cmd_ff == cqhs_pkg::CMD_REPORT;
   assign sts.col_bad   = col_bad;
   assign sts.walk_done = wcnt_ff == (BIN_BITS + 1)'(QUAL_LEVELS);
   assign sts.emit_last = k_ff == cqhs_pkg::STAT_CNT_N;
   assign sts.out_free  = !out_valid_ff || rsp_ready;

endmodule

[rtl/column_quality_histogram_stats_top.sv]
// add: capture, then lookup of the column and histogram words, then the status is written to
// the output register once it is free; no new transaction is taken until then. report: capture,
// lookup, a walk over every bin reading one histogram bin per cycle, a finish step, 15 results
// reset: synchronous, clears control and config, then a clearing pass over all MAX_COLUMNS *
// 2^ceil(log2(QUAL_LEVELS)) histogram entries (32768 by default) with req ready low
module column_quality_histogram_stats_top #(
   parameter int MAX_COLUMNS = 256,
   parameter int QUAL_LEVELS = 128,
   parameter int COUNT_BITS  = 32
) (
   input  logic       clock,
   input  logic       reset,
   cqhs_req_if.sink   req_chan,
   cqhs_rsp_if.source rsp_chan,
   input  logic       csr_we,
   input  logic       csr_index,
   input  logic [7:0] csr_wdata
);

   // configuration registers; the user must write them only while idle, the block does not enforce it
   logic              has_quality_ff;
   logic signed [7:0] min_quality_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         has_quality_ff <= cqhs_pkg::HAS_QUALITY_RESET;
         min_quality_ff <= cqhs_pkg::MIN_QUALITY_RESET;
      end else if (csr_we) begin
         unique case (csr_index)
            cqhs_pkg::CSR_HAS_QUALITY: has_quality_ff <= csr_wdata[0];
            cqhs_pkg::CSR_MIN_QUALITY: min_quality_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   // command and status between sequencer and datapath
   cqhs_pkg::cmd_type cmd;
   cqhs_pkg::sts_type sts;

   // sequencer: clear sweep, transaction capture, lookup, walk, emit
   cqhs_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_ready (req_chan.ready),
      .sts       (sts),
      .cmd       (cmd)
   );

   // datapath: column memory, histogram memory, quartile walk, output register
   cqhs_datapath #(
      .MAX_COLUMNS (MAX_COLUMNS),
      .QUAL_LEVELS (QUAL_LEVELS),
      .COUNT_BITS  (COUNT_BITS)
   ) u_datapath (
      .clock         (clock),
      .reset         (reset),
      .cmd           (cmd),
      .sts           (sts),
      .has_quality   (has_quality_ff),
      .min_quality   (min_quality_ff),
      .req_command   (req_chan.command),
      .req_column    (req_chan.column),
      .req_base      (req_chan.base),
      .req_quality   (req_chan.quality),
      .req_weight    (req_chan.weight),
      .rsp_valid     (rsp_chan.valid),
      .rsp_ready     (rsp_chan.ready),
      .rsp_stat_code (rsp_chan.stat_code),
      .rsp_value     (rsp_chan.value),
      .rsp_last      (rsp_chan.last)
   );

endmodule

[bench/tb.sv]
module tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int NUM_COLS     = 256;
   localparam int NUM_LEVELS   = 128;
   localparam longint CNT_MAX  = 64'hFFFF_FFFF;
   localparam longint SUM_HI   = 64'sd281474976710655;
   localparam longint SUM_LO   = -SUM_HI - 1;
   localparam int WATCHDOG_MAX = 100000;
   localparam int DRAIN_CYCLES = 300;
   localparam int RAND_PER_PHASE = 86;

   typedef struct {
      logic              command;
      logic [7:0]        column;
      logic [7:0]        base;
      logic signed [7:0] quality;
      logic [23:0]       weight;
   } base_obs_type;

   typedef struct {
      logic [3:0]  stat_code;
      logic [48:0] value;
      logic        last;
   } stat_type;

   logic clock;
   logic reset;
   logic csr_we;
   logic csr_index;
   logic [7:0] csr_wdata;

   cqhs_req_if req_if();
   cqhs_rsp_if rsp_if();

   column_quality_histogram_stats_top i_dut (
      .clock     (clock),
      .reset     (reset),
      .req_chan  (req_if),
      .rsp_chan  (rsp_if),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   // pending observations for the driver and statistics still owed by the block
   base_obs_type pending_obs[$];
   stat_type     stat_expect[$];
   base_obs_type obs_on_bus;

   int  error_count = 0;
   int  obs_driven = 0;
   bit  hold_sender = 0;
   int  quiet_cycles = 0;

   // shadow copy of the block's configuration and column state
   bit     shadow_has_qual;
   int     shadow_min_qual;
   int     col_min_q[NUM_COLS];
   int     col_max_q[NUM_COLS];
   longint col_qual_sum[NUM_COLS];
   longint col_weight[NUM_COLS];
   longint col_samples[NUM_COLS];
   longint col_nuc[NUM_COLS][cqhs_pkg::NUM_BASES];
   longint qual_hist[NUM_COLS][NUM_LEVELS];

   // clock
   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   function automatic longint sat_count(longint a, longint b);
      longint s;
      s = a + b;
      return (s > CNT_MAX) ? CNT_MAX : s;
   endfunction

   function automatic int nucleotide_slot(logic [7:0] b);
      case (b)
         cqhs_pkg::ASCII_A: return 0;
         cqhs_pkg::ASCII_C: return 1;
         cqhs_pkg::ASCII_G: return 2;
         cqhs_pkg::ASCII_T: return 3;
         cqhs_pkg::ASCII_N: return 4;
         default: return -1;
      endcase
   endfunction

   // bin that holds the order statistic of a zero based rank
   function automatic int rank_bin(int col, longint rank);
      longint cum;
      int top;
      cum = 0;
      top = 0;
      for (int i = 0; i < NUM_LEVELS; i++) begin
         if (qual_hist[col][i] != 0) begin
            top = i;
            cum += qual_hist[col][i];
            if (cum > rank) return i;
         end
      end
      return top;
   endfunction

   function automatic void push_stat(logic [3:0] code, longint v, logic last);
      stat_type s;
      s.stat_code = code;
      s.value     = v[48:0];
      s.last      = last;
      stat_expect.push_back(s);
   endfunction

   // update the shadow state and queue the statistics an observation causes
   function automatic void predict_column_stats(base_obs_type o);
      int c;
      int slot;
      int bin;
      int q;
      longint n, q1, med, q3, iqr, lw, rw, s;
      c    = o.column;
      q    = o.quality;
      slot = nucleotide_slot(o.base);
      bin  = q - shadow_min_qual;
      if (o.command == cqhs_pkg::CMD_ADD) begin
         if (slot < 0) begin
            push_stat(cqhs_pkg::STAT_STATUS, cqhs_pkg::STS_BAD_BASE, 1'b1);
            return;
         end
         if (shadow_has_qual && (bin < 0 || bin >= NUM_LEVELS)) begin
            push_stat(cqhs_pkg::STAT_STATUS, cqhs_pkg::STS_BAD_QUAL, 1'b1);
            return;
         end
         if (shadow_has_qual) begin
            if (col_min_q[c] > q) col_min_q[c] = q;
            if (col_max_q[c] < q) col_max_q[c] = q;
            s = col_qual_sum[c] + q;
            col_qual_sum[c] = (s > SUM_HI) ? SUM_HI : ((s < SUM_LO) ? SUM_LO : s);
            qual_hist[c][bin] = sat_count(qual_hist[c][bin], 1);
            col_samples[c] = sat_count(col_samples[c], 1);
         end
         col_weight[c] = sat_count(col_weight[c], o.weight);
         col_nuc[c][slot] = sat_count(col_nuc[c][slot], o.weight);
         push_stat(cqhs_pkg::STAT_STATUS, cqhs_pkg::STS_OK, 1'b1);
         return;
      end
      n = col_samples[c];
      q1 = 0; med = 0; q3 = 0; iqr = 0; lw = 0; rw = 0;
      if (n != 0) begin
         q1  = rank_bin(c, n / 4) + shadow_min_qual;
         med = rank_bin(c, n / 2) + shadow_min_qual;
         q3  = rank_bin(c, n * 3 / 4) + shadow_min_qual;
         iqr = q3 - q1;
         lw  = q1 - iqr * 3 / 2;
         if (lw < col_min_q[c]) lw = col_min_q[c];
         rw  = q3 + iqr * 3 / 2;
         if (rw > col_max_q[c]) rw = col_max_q[c];
      end
      push_stat(cqhs_pkg::STAT_COUNT, col_weight[c], 1'b0);
      push_stat(cqhs_pkg::STAT_MIN, col_min_q[c], 1'b0);
      push_stat(cqhs_pkg::STAT_MAX, col_max_q[c], 1'b0);
      push_stat(cqhs_pkg::STAT_SUM, col_qual_sum[c], 1'b0);
      push_stat(cqhs_pkg::STAT_Q1, q1, 1'b0);
      push_stat(cqhs_pkg::STAT_MEDIAN, med, 1'b0);
      push_stat(cqhs_pkg::STAT_Q3, q3, 1'b0);
      push_stat(cqhs_pkg::STAT_IQR, iqr, 1'b0);
      push_stat(cqhs_pkg::STAT_LWHISK, lw, 1'b0);
      push_stat(cqhs_pkg::STAT_RWHISK, rw, 1'b0);
      push_stat(cqhs_pkg::STAT_CNT_A, col_nuc[c][0], 1'b0);
      push_stat(cqhs_pkg::STAT_CNT_C, col_nuc[c][1], 1'b0);
      push_stat(cqhs_pkg::STAT_CNT_G, col_nuc[c][2], 1'b0);
      push_stat(cqhs_pkg::STAT_CNT_T, col_nuc[c][3], 1'b0);
      push_stat(cqhs_pkg::STAT_CNT_N, col_nuc[c][4], 1'b1);
   endfunction

   // idle percentages: sender-light first, then receiver-light, then none
   function automatic bit sender_idles();
      int pct;
      pct = (obs_driven < 150) ? 7 : ((obs_driven < 300) ? 85 : 0);
      return $urandom_range(0, 99) < pct;
   endfunction

   function automatic bit receiver_stalls();
      int pct;
      pct = (obs_driven < 150) ? 85 : ((obs_driven < 300) ? 7 : 0);
      return $urandom_range(0, 99) < pct;
   endfunction

   // driver: predicts each accepted transaction, then offers the next one
   always @(posedge clock) begin
      if (reset) begin
         req_if.valid <= 1'b0;
      end else if (!req_if.valid || req_if.ready) begin
         if (req_if.valid) predict_column_stats(obs_on_bus);
         if (pending_obs.size() > 0 && !hold_sender && !sender_idles()) begin
            obs_on_bus = pending_obs.pop_front();
            obs_driven++;
            req_if.valid   <= 1'b1;
            req_if.command <= obs_on_bus.command;
            req_if.column  <= obs_on_bus.column;
            req_if.base    <= obs_on_bus.base;
            req_if.quality <= obs_on_bus.quality;
            req_if.weight  <= obs_on_bus.weight;
         end else begin
            req_if.valid <= 1'b0;
         end
      end
   end

   // monitor: checks each accepted statistic against the oldest expectation
   always @(posedge clock) begin
      stat_type e;
      if (reset) begin
         rsp_if.ready <= 1'b0;
      end else begin
         if (rsp_if.valid && rsp_if.ready) begin
            if (stat_expect.size() == 0) begin
               $error("unexpected statistic code %0d value %0d", rsp_if.stat_code,
                      rsp_if.value);
               error_count++;
            end else begin
               e = stat_expect.pop_front();
               if (rsp_if.stat_code !== e.stat_code) begin
                  $error("stat_code expected %0d actual %0d", e.stat_code, rsp_if.stat_code);
                  error_count++;
               end
               if (rsp_if.value !== e.value) begin
                  $error("value expected %0d actual %0d (code %0d)", $signed(e.value),
                         rsp_if.value, e.stat_code);
                  error_count++;
               end
               if (rsp_if.last !== e.last) begin
                  $error("last expected %0d actual %0d", e.last, rsp_if.last);
                  error_count++;
               end
            end
         end
         rsp_if.ready <= !receiver_stalls();
      end
   end

   // watchdog: cycles without any accepted transaction
   always @(posedge clock) begin
      if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= WATCHDOG_MAX) begin
         $display("Test completed with failures");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   task automatic write_reg(logic idx, logic [7:0] data);
      @(posedge clock);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(posedge clock);
      csr_we    <= 1'b0;
      if (idx == cqhs_pkg::CSR_HAS_QUALITY) shadow_has_qual = data[0];
      else shadow_min_qual = $signed(data);
   endtask

   task automatic wait_drained();
      while (pending_obs.size() > 0 || req_if.valid) @(posedge clock);
      while (stat_expect.size() > 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic queue_obs(logic cmd, logic [7:0] col, logic [7:0] b,
                            logic signed [7:0] q, logic [23:0] w);
      base_obs_type o;
      o.command = cmd;
      o.column  = col;
      o.base    = b;
      o.quality = q;
      o.weight  = w;
      pending_obs.push_back(o);
   endtask

   // mostly well formed adds on a few hot columns, some reports, some noise
   task automatic queue_random(int count);
      logic [7:0] nucs[5];
      int q;
      logic [23:0] w;
      nucs = '{cqhs_pkg::ASCII_A, cqhs_pkg::ASCII_C, cqhs_pkg::ASCII_G,
               cqhs_pkg::ASCII_T, cqhs_pkg::ASCII_N};
      for (int i = 0; i < count; i++) begin
         q = shadow_min_qual + $urandom_range(0, NUM_LEVELS - 1);
         if (q > 127) q = shadow_min_qual;
         if ($urandom_range(0, 99) < 10) q = $signed(8'($urandom));
         case ($urandom_range(0, 9))
            0:       w = 24'hFF_FFFF;
            1:       w = 24'($urandom_range(1, 24'hFF_FFFF));
            default: w = 24'($urandom_range(1, 10));
         endcase
         queue_obs(($urandom_range(0, 99) < 12) ? cqhs_pkg::CMD_REPORT : cqhs_pkg::CMD_ADD,
                   ($urandom_range(0, 99) < 70) ? 8'($urandom_range(0, 5)) : 8'($urandom),
                   ($urandom_range(0, 99) < 85) ? nucs[$urandom_range(0, 4)] : 8'($urandom),
                   8'(q), w);
      end
   endtask

   // stimulus and end of run
   initial begin
      req_if.valid   = 1'b0;
      req_if.command = cqhs_pkg::CMD_ADD;
      req_if.column  = '0;
      req_if.base    = '0;
      req_if.quality = '0;
      req_if.weight  = 24'd1;
      rsp_if.ready   = 1'b0;
      csr_we         = 1'b0;
      csr_index      = cqhs_pkg::CSR_HAS_QUALITY;
      csr_wdata      = '0;
      for (int c = 0; c < NUM_COLS; c++) begin
         col_min_q[c] = 100;
         col_max_q[c] = -100;
         col_qual_sum[c] = 0;
         col_weight[c] = 0;
         col_samples[c] = 0;
         for (int k = 0; k < cqhs_pkg::NUM_BASES; k++) col_nuc[c][k] = 0;
         for (int b = 0; b < NUM_LEVELS; b++) qual_hist[c][b] = 0;
      end
      shadow_has_qual = cqhs_pkg::HAS_QUALITY_RESET;
      shadow_min_qual = cqhs_pkg::MIN_QUALITY_RESET;

      reset = 1'b1;
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      // the block clears its memories before taking the first transaction
      while (!req_if.ready) @(posedge clock);
      write_reg(cqhs_pkg::CSR_HAS_QUALITY, 8'd1);
      write_reg(cqhs_pkg::CSR_MIN_QUALITY, 8'hF1);

      // directed: every nucleotide, bin edges, bad base, bad quality, weight edges
      queue_obs(cqhs_pkg::CMD_REPORT, 8'd0, cqhs_pkg::ASCII_A, 8'sd0, 24'd1);
      queue_obs(cqhs_pkg::CMD_ADD, 8'd0, cqhs_pkg::ASCII_A, -8'sd15, 24'd1);
      queue_obs(cqhs_pkg::CMD_ADD, 8'd0, cqhs_pkg::ASCII_C, 8'sd112, 24'hFF_FFFF);
      queue_obs(cqhs_pkg::CMD_ADD, 8'd0, cqhs_pkg::ASCII_G, 8'sd30, 24'd7);
      queue_obs(cqhs_pkg::CMD_ADD, 8'd0, cqhs_pkg::ASCII_T, 8'sd40, 24'd2);
      queue_obs(cqhs_pkg::CMD_ADD, 8'd0, cqhs_pkg::ASCII_N, 8'sd40, 24'd3);
      queue_obs(cqhs_pkg::CMD_ADD, 8'd0, 8'h58, 8'sd20, 24'd1);
      queue_obs(cqhs_pkg::CMD_ADD, 8'd0, 8'h00, 8'sd20, 24'd1);
      queue_obs(cqhs_pkg::CMD_ADD, 8'd0, 8'hFF, 8'sd20, 24'd1);
      queue_obs(cqhs_pkg::CMD_ADD, 8'd0, cqhs_pkg::ASCII_A, -8'sd16, 24'd1);
      queue_obs(cqhs_pkg::CMD_ADD, 8'd0, cqhs_pkg::ASCII_A, 8'sd113, 24'd1);
      queue_obs(cqhs_pkg::CMD_ADD, 8'd0, cqhs_pkg::ASCII_A, -8'sd128, 24'd1);
      queue_obs(cqhs_pkg::CMD_ADD, 8'd0, cqhs_pkg::ASCII_A, 8'sd127, 24'd1);
      queue_obs(cqhs_pkg::CMD_REPORT, 8'd0, cqhs_pkg::ASCII_A, 8'sd0, 24'd1);
      queue_obs(cqhs_pkg::CMD_REPORT, 8'd200, 8'hFF, -8'sd1, 24'hFF_FFFF);
      queue_obs(cqhs_pkg::CMD_ADD, 8'd255, cqhs_pkg::ASCII_T, 8'sd0, 24'd5);
      queue_obs(cqhs_pkg::CMD_REPORT, 8'd255, cqhs_pkg::ASCII_A, 8'sd0, 24'd1);
      queue_random(RAND_PER_PHASE);
      wait_drained();

      // quality ignored: only the weight count and base counts move
      write_reg(cqhs_pkg::CSR_HAS_QUALITY, 8'd0);
      write_reg(cqhs_pkg::CSR_MIN_QUALITY, 8'hF1);
      queue_random(RAND_PER_PHASE);
      wait_drained();

      // lowest offset: only negative qualities fit
      write_reg(cqhs_pkg::CSR_HAS_QUALITY, 8'd1);
      write_reg(cqhs_pkg::CSR_MIN_QUALITY, 8'h80);
      queue_random(RAND_PER_PHASE / 2);
      // sender holds off until the block has answered everything
      hold_sender = 1'b1;
      while (req_if.valid || stat_expect.size() > 0) @(posedge clock);
      hold_sender = 1'b0;
      queue_random(RAND_PER_PHASE / 2);
      wait_drained();

      // highest offset: a single valid quality
      write_reg(cqhs_pkg::CSR_MIN_QUALITY, 8'h7F);
      queue_random(RAND_PER_PHASE);
      wait_drained();

      write_reg(cqhs_pkg::CSR_MIN_QUALITY, 8'h00);
      queue_random(RAND_PER_PHASE);
      wait_drained();

      if (error_count == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

endmodule

[filelist.f]
rtl/cqhs_pkg.sv
rtl/cqhs_ifs.sv
rtl/cqhs_ctrl.sv
rtl/cqhs_datapath.sv
rtl/column_quality_histogram_stats_top.sv
bench/tb.sv
